// ===== rtl/segment_triangle_intersect_top_assert.svh =====
// assertion macros for the segment / triangle intersection block
// depends on nothing; included by the top level
`ifndef SEGMENT_TRIANGLE_INTERSECT_TOP_ASSERT_SVH
`define SEGMENT_TRIANGLE_INTERSECT_TOP_ASSERT_SVH

// implication checked at every rising edge outside reset
`define STI_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// condition that must hold at every rising edge outside reset
`define STI_ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant check failed");

`endif

// ===== rtl/sti_pkg.sv =====
// types and constants for the segment / triangle intersection block
// no dependencies
`timescale 1ns / 1ps

package sti_pkg;

  localparam int COORD_BITS = 24;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int CROSS_W    = PROD_W + 1;
  localparam int SPLIT_W    = CROSS_W / 2;
  localparam int PL_W       = DIFF_W + SPLIT_W + 1;
  localparam int PH_W       = DIFF_W + CROSS_W - SPLIT_W;
  localparam int DOT_W      = DIFF_W + CROSS_W + 2;
  localparam int TIME_W     = 17;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SEG_START_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_START_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_START_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_END_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_END_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_END_Z   = 3'd5;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t vert0_x;
    coord_t vert0_y;
    coord_t vert0_z;
    coord_t vert1_x;
    coord_t vert1_y;
    coord_t vert1_z;
    coord_t vert2_x;
    coord_t vert2_y;
    coord_t vert2_z;
  } tri_word_t;

  typedef struct packed {
    logic              hit;
    logic [TIME_W-1:0] hit_time;
  } res_word_t;

endpackage

// ===== rtl/segment_triangle_intersect_top.sv =====
// segment / triangle intersection, one-sided barycentric test, deep pipeline
// depends on sti_pkg, sti_div and segment_triangle_intersect_top_assert.svh
//
//   channel  signals                                   direction  word
//   tri      tri_valid tri_stall tri_data              in         tri_word_t
//   res      res_valid res_stall res_data              out        res_word_t
//   cfg      cfg_valid cfg_ready cfg_index cfg_data    in         segment register
//
// one triangle per cycle while res_stall is low; 7 arithmetic stages, 17 divider stages
// the divider emits one quotient bit per stage, the dot products take three stages
// rst is synchronous; it clears the valid bits and the segment registers
// each stage holds only while the stage after it is stalled and full, so bubbles close up
// cfg_ready is always high
`timescale 1ns / 1ps
`include "segment_triangle_intersect_top_assert.svh"

module segment_triangle_intersect_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            tri_valid,
  output logic                            tri_stall,
  input  sti_pkg::tri_word_t              tri_data,
  output logic                            res_valid,
  input  logic                            res_stall,
  output sti_pkg::res_word_t              res_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sti_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sti_pkg::COORD_BITS-1:0]  cfg_data
);

  localparam int DW  = sti_pkg::DIFF_W;
  localparam int PW  = sti_pkg::PROD_W;
  localparam int CW  = sti_pkg::CROSS_W;
  localparam int SW  = sti_pkg::SPLIT_W;
  localparam int LW  = sti_pkg::PL_W;
  localparam int HW  = sti_pkg::PH_W;
  localparam int OW  = sti_pkg::DOT_W;
  localparam int VWW = OW + 1;

  // segment registers
  sti_pkg::coord_t ss [3];
  sti_pkg::coord_t se [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        ss[i] <= '0;
        se[i] <= '0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sti_pkg::REG_SEG_START_X: ss[0] <= cfg_data;
        sti_pkg::REG_SEG_START_Y: ss[1] <= cfg_data;
        sti_pkg::REG_SEG_START_Z: ss[2] <= cfg_data;
        sti_pkg::REG_SEG_END_X:   se[0] <= cfg_data;
        sti_pkg::REG_SEG_END_Y:   se[1] <= cfg_data;
        sti_pkg::REG_SEG_END_Z:   se[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [DW-1:0] qp [3];
  always_comb begin
    for (int i = 0; i < 3; i++) qp[i] = DW'(ss[i]) - DW'(se[i]);
  end

  // stage enables
  logic v1, v2, v3, v4, v5, v6, v7;
  logic en1, en2, en3, en4, en5, en6, en7;
  logic div_stall;

  assign en7 = !v7 || !div_stall;
  assign en6 = !v6 || en7;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign tri_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (en1) v1 <= tri_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
      if (en7) v7 <= v6;
    end
  end

  // stage 1: edge vectors
  sti_pkg::coord_t p0 [3];
  sti_pkg::coord_t p1 [3];
  sti_pkg::coord_t p2 [3];
  assign p0[0] = tri_data.vert0_x;
  assign p0[1] = tri_data.vert0_y;
  assign p0[2] = tri_data.vert0_z;
  assign p1[0] = tri_data.vert1_x;
  assign p1[1] = tri_data.vert1_y;
  assign p1[2] = tri_data.vert1_z;
  assign p2[0] = tri_data.vert2_x;
  assign p2[1] = tri_data.vert2_y;
  assign p2[2] = tri_data.vert2_z;

  logic signed [DW-1:0] ab1 [3];
  logic signed [DW-1:0] ac1 [3];
  logic signed [DW-1:0] ap1 [3];

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < 3; i++) begin
        ab1[i] <= DW'(p1[i]) - DW'(p0[i]);
        ac1[i] <= DW'(p2[i]) - DW'(p0[i]);
        ap1[i] <= DW'(ss[i]) - DW'(p0[i]);
      end
    end
  end

  // stage 2: cross product terms
  logic signed [PW-1:0] nm2 [6];
  logic signed [PW-1:0] xm2 [6];
  logic signed [DW-1:0] ab2 [3];
  logic signed [DW-1:0] ac2 [3];
  logic signed [DW-1:0] ap2 [3];

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int i = 0; i < 3; i++) begin
        nm2[2*i]   <= ab1[(i+1)%3] * ac1[(i+2)%3];
        nm2[2*i+1] <= ab1[(i+2)%3] * ac1[(i+1)%3];
        xm2[2*i]   <= qp[(i+1)%3] * ap1[(i+2)%3];
        xm2[2*i+1] <= qp[(i+2)%3] * ap1[(i+1)%3];
        ab2[i] <= ab1[i];
        ac2[i] <= ac1[i];
        ap2[i] <= ap1[i];
      end
    end
  end

  // stage 3: normal and qp x ap
  logic signed [CW-1:0] nrm3 [3];
  logic signed [CW-1:0] ex3  [3];
  logic signed [DW-1:0] ab3  [3];
  logic signed [DW-1:0] ac3  [3];
  logic signed [DW-1:0] ap3  [3];

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int i = 0; i < 3; i++) begin
        nrm3[i] <= CW'(nm2[2*i]) - CW'(nm2[2*i+1]);
        ex3[i]  <= CW'(xm2[2*i]) - CW'(xm2[2*i+1]);
        ab3[i]  <= ab2[i];
        ac3[i]  <= ac2[i];
        ap3[i]  <= ap2[i];
      end
    end
  end

  // stage 4: split partial products of d, t, v and ab.e
  logic signed [DW-1:0] da [4][3];
  logic signed [CW-1:0] dc [4][3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      da[0][i] = qp[i];
      dc[0][i] = nrm3[i];
      da[1][i] = ap3[i];
      dc[1][i] = nrm3[i];
      da[2][i] = ac3[i];
      dc[2][i] = ex3[i];
      da[3][i] = ab3[i];
      dc[3][i] = ex3[i];
    end
  end

  logic signed [LW-1:0] pl4 [4][3];
  logic signed [HW-1:0] ph4 [4][3];

  always_ff @(posedge clk) begin
    if (en4) begin
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 3; i++) begin
          pl4[k][i] <= da[k][i] * $signed({1'b0, dc[k][i][SW-1:0]});
          ph4[k][i] <= da[k][i] * $signed(dc[k][i][CW-1:SW]);
        end
      end
    end
  end

  // stage 5: full products
  logic signed [OW-1:0] pr5 [4][3];

  always_ff @(posedge clk) begin
    if (en5) begin
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 3; i++) begin
          pr5[k][i] <= (OW'(ph4[k][i]) <<< SW) + OW'(pl4[k][i]);
        end
      end
    end
  end

  // stage 6: dot products
  logic signed [OW-1:0] dot6 [4];

  always_ff @(posedge clk) begin
    if (en6) begin
      for (int k = 0; k < 4; k++) dot6[k] <= pr5[k][0] + pr5[k][1] + pr5[k][2];
    end
  end

  // stage 7: bound checks
  logic signed [OW-1:0]  d6, t6, v6d, w6;
  logic signed [VWW-1:0] vw6;
  logic                  hit6;
  assign d6   = dot6[0];
  assign t6   = dot6[1];
  assign v6d  = dot6[2];
  assign w6   = -dot6[3];
  assign vw6  = VWW'(v6d) + VWW'(w6);
  assign hit6 = (d6 > 0) && !t6[OW-1] && (t6 <= d6) && !v6d[OW-1] && (v6d <= d6)
                && !w6[OW-1] && (vw6 <= VWW'(d6));

  logic          h7;
  logic [OW-1:0] t7;
  logic [OW-1:0] d7;

  always_ff @(posedge clk) begin
    if (en7) begin
      h7 <= hit6;
      t7 <= t6;
      d7 <= d6;
    end
  end

  sti_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v7),
    .in_stall  (div_stall),
    .in_hit    (h7),
    .in_num    (t7),
    .in_den    (d7),
    .out_valid (res_valid),
    .out_stall (res_stall),
    .out_data  (res_data)
  );

  `STI_ASSERT_IMPL(a_hit_bounds, clk, rst, v7 && h7, !d7[OW-1] && (d7 != '0) && (t7 <= d7))
  `STI_ASSERT_IMPL(a_miss_zero, clk, rst, res_valid && !res_data.hit, res_data.hit_time == '0)
  `STI_ASSERT_IMPL(a_full_time, clk, rst, res_valid && res_data.hit_time[16],
                   res_data.hit_time[15:0] == '0)
  `STI_ASSERT_ALWAYS(a_stall_chain, clk, rst, !tri_stall || (v1 && v2 && v3 && v4 && v5 && v6 && v7))

endmodule

// ===== rtl/sti_div.sv =====
// pipelined restoring divider producing floor(65536 * num / den) for hits, zero for misses, one bit per stage
// depends on sti_pkg
`timescale 1ns / 1ps

module sti_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_hit,
  input  logic [sti_pkg::DOT_W-1:0]  in_num,
  input  logic [sti_pkg::DOT_W-1:0]  in_den,
  output logic                       out_valid,
  input  logic                       out_stall,
  output sti_pkg::res_word_t         out_data
);

  localparam int NSTG  = sti_pkg::TIME_W;
  localparam int REM_W = sti_pkg::DOT_W + 1;

  logic                          vld [NSTG];
  logic                          ht  [NSTG];
  logic [REM_W-1:0]              rem [NSTG];
  logic [sti_pkg::DOT_W-1:0]     dn  [NSTG];
  logic [sti_pkg::TIME_W-1:0]    q   [NSTG];
  logic [NSTG:0]                 en;

  assign en[NSTG] = !out_stall;
  assign in_stall = !en[0];

  // first quotient bit (t == d gives 1.0)
  logic             ge0;
  logic [REM_W-1:0] num_ext;
  logic [REM_W-1:0] den_ext;
  assign num_ext = {1'b0, in_num};
  assign den_ext = {1'b0, in_den};
  assign ge0     = num_ext >= den_ext;

  assign en[0] = !vld[0] || en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en[0]) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ht[0]  <= in_hit;
      dn[0]  <= in_den;
      rem[0] <= ge0 ? (num_ext - den_ext) : num_ext;
      q[0]   <= {{(sti_pkg::TIME_W-1){1'b0}}, ge0};
    end
  end

  for (genvar k = 1; k < NSTG; k++) begin : g_step
    logic [REM_W-1:0] sh;
    logic [REM_W-1:0] dx;
    logic             ge;
    assign sh = {rem[k-1][REM_W-2:0], 1'b0};
    assign dx = {1'b0, dn[k-1]};
    assign ge = sh >= dx;
    assign en[k] = !vld[k] || en[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en[k]) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        ht[k]  <= ht[k-1];
        dn[k]  <= dn[k-1];
        rem[k] <= ge ? (sh - dx) : sh;
        q[k]   <= {q[k-1][sti_pkg::TIME_W-2:0], ge};
      end
    end
  end

  assign out_valid         = vld[NSTG-1];
  assign out_data.hit      = ht[NSTG-1];
  assign out_data.hit_time = ht[NSTG-1] ? q[NSTG-1] : '0;

endmodule
